// ===== src/afd_pkg.sv =====
// Package: shared types and constants for the accessory frame deframer.
package afd_pkg;

    localparam logic [7:0] PRE_FIRST  = 8'hFF;
    localparam logic [7:0] PRE_SECOND = 8'h55;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

    typedef enum logic [0:0] {
        REQ_BYTE    = 1'b0,
        REQ_TIMEOUT = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        STAT_NONE    = 3'd0,
        STAT_GOOD    = 3'd1,
        STAT_BADSUM  = 3'd2,
        STAT_BADLEN  = 3'd3,
        STAT_TIMEOUT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_LEN,
        ST_BODY
    } t_state;

    typedef struct packed {
        logic [7:0] payload_length;
        t_status    status;
        logic       frame_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } t_result;

endpackage

// ===== src/afd_parse.sv =====
// Frame parser: framing state and per-word result decode.
module afd_parse
    import afd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_req       i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_max_length,
    output t_result    o_result
);

    t_state     r_state,        n_state;
    logic [7:0] r_last_byte,    n_last_byte;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_remain,       n_remain;
    logic [7:0] r_sum,          n_sum;
    logic [7:0] w_sum_plus;

    assign w_sum_plus = r_sum + i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_HUNT;
            r_last_byte    <= '0;
            r_frame_length <= '0;
            r_remain       <= '0;
            r_sum          <= '0;
        end else if (i_step) begin
            r_state        <= n_state;
            r_last_byte    <= n_last_byte;
            r_frame_length <= n_frame_length;
            r_remain       <= n_remain;
            r_sum          <= n_sum;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_last_byte    = r_last_byte;
        n_frame_length = r_frame_length;
        n_remain       = r_remain;
        n_sum          = r_sum;
        o_result       = '0;
        if (i_req_type == REQ_TIMEOUT) begin
            if (r_state != ST_HUNT) begin
                o_result.frame_end      = 1'b1;
                o_result.status         = STAT_TIMEOUT;
                o_result.payload_length = r_frame_length;
            end
            n_state        = ST_HUNT;
            n_last_byte    = '0;
            n_frame_length = '0;
            n_remain       = '0;
            n_sum          = '0;
        end else begin
            n_last_byte = i_rx_byte;
            unique case (r_state)
                ST_HUNT: begin
                    if (r_last_byte == PRE_FIRST && i_rx_byte == PRE_SECOND) begin
                        n_state        = ST_LEN;
                        n_frame_length = '0;
                        n_sum          = '0;
                    end
                end
                ST_LEN: begin
                    if (i_rx_byte == '0 || i_rx_byte > i_max_length) begin
                        o_result.frame_end      = 1'b1;
                        o_result.status         = STAT_BADLEN;
                        o_result.payload_length = i_rx_byte;
                        n_state        = ST_HUNT;
                        n_frame_length = '0;
                        n_sum          = '0;
                        n_remain       = '0;
                    end else begin
                        n_state        = ST_BODY;
                        n_frame_length = i_rx_byte;
                        n_sum          = i_rx_byte;
                        n_remain       = i_rx_byte;
                    end
                end
                ST_BODY: begin
                    if (r_remain == '0) begin
                        // checksum word: length + payload + checksum must be 0 mod 256
                        o_result.frame_end      = 1'b1;
                        o_result.status = (w_sum_plus == '0) ? STAT_GOOD : STAT_BADSUM;
                        o_result.payload_length = r_frame_length;
                        n_state        = ST_HUNT;
                        n_frame_length = '0;
                        n_sum          = '0;
                    end else begin
                        o_result.out_byte   = i_rx_byte;
                        o_result.byte_valid = 1'b1;
                        n_sum    = w_sum_plus;
                        n_remain = r_remain - 8'd1;
                    end
                end
                default: begin
                    n_state = ST_HUNT;
                end
            endcase
        end
    end

    a_valid_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.byte_valid |-> !o_result.frame_end)
        else $error("payload word flagged as frame end");

    a_end_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.frame_end |-> (o_result.status != STAT_NONE))
        else $error("frame end without a verdict");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_req_type == REQ_TIMEOUT) |=>
            (r_state == ST_HUNT && r_last_byte == '0 && r_frame_length == '0))
        else $error("timeout did not return to hunting");

    a_hunt_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HUNT) |-> (r_frame_length == '0 && r_sum == '0))
        else $error("stale frame state while hunting");

endmodule

// ===== src/accessory_frame_deframer_unit.sv =====
// Top level: accessory frame deframer with input and result registers.
//
//  channel  | dir | tdata                              | tuser                   | tlast
//  s_axis   | in  | [7:0] rx_byte                      | [0] req_type            | -
//  m_axis   | out | [7:0] out_byte, [15:8] payload_len | [0] byte_valid, [3:1] st | frame_end
//  max_len  | in  | i_max_length, i_max_length_we      | -                       | -
//
// One word in, one word out; a word can enter every cycle while m_axis is ready.
// Each word passes the input register, then is parsed into the result register.
// The framing state advances only when the input register moves into the result register.
// Backpressure on m_axis stalls the result register, then the input register.
// Reset (synchronous, active low) returns to hunting and sets max_length to 255.
module accessory_frame_deframer_unit
    import afd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] payload_length
    output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] status
    output logic        m_axis_tlast,   // frame_end
    input  logic        i_max_length_we,
    input  logic [7:0]  i_max_length
);

    logic       r_in_valid;
    t_req       r_in_req;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_max_length;
    logic       w_step;
    t_result    w_result;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_max_length_we) begin
            r_max_length <= i_max_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req  <= t_req'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
    end

    afd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_req_type   (r_in_req),
        .i_rx_byte    (r_in_byte),
        .i_max_length (r_max_length),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.payload_length, r_out.out_byte};
    assign m_axis_tuser  = {r_out.status, r_out.byte_valid};
    assign m_axis_tlast  = r_out.frame_end;

endmodule

// ===== sim/tb.sv =====
// Testbench for accessory_frame_deframer_unit: directed and random framed byte streams checked word by word.
module tb
    import afd_pkg::*;
();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0; // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] out_byte, [15:8] payload_length
    logic [3:0]  m_axis_tuser;        // [0] byte_valid, [3:1] status
    logic        m_axis_tlast;        // frame_end
    logic        i_max_length_we = 1'b0;
    logic [7:0]  i_max_length = MAX_LENGTH_RESET;

    accessory_frame_deframer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .i_max_length_we (i_max_length_we),
        .i_max_length    (i_max_length)
    );

    class deframe_board;
        logic [7:0] max_len;
        t_state     parse_st;
        logic [7:0] prev_byte;
        logic [7:0] frame_len;
        logic [7:0] taken;
        logic [7:0] sum;
        t_result    result_q[$];
        int         accepted;
        int         checked;
        int         errors;

        function new();
            max_len = MAX_LENGTH_RESET;
            accepted = 0;
            checked = 0;
            errors = 0;
            hunt();
        endfunction

        function void hunt();
            parse_st = ST_HUNT;
            prev_byte = '0;
            frame_len = '0;
            taken = '0;
            sum = '0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // Advance the framing state by one accepted word and queue its result.
        function void note_word(t_req req, logic [7:0] b);
            t_result r;
            r = '0;
            r.status = STAT_NONE;
            accepted++;
            if (req == REQ_TIMEOUT) begin
                if (parse_st != ST_HUNT) begin
                    r.frame_end = 1'b1;
                    r.status = STAT_TIMEOUT;
                    r.payload_length = frame_len;
                end
                hunt();
            end else begin
                case (parse_st)
                    ST_HUNT: begin
                        if (prev_byte == PRE_FIRST && b == PRE_SECOND) begin
                            parse_st = ST_LEN;
                            frame_len = '0;
                            sum = '0;
                        end
                    end
                    ST_LEN: begin
                        if (b == 8'd0 || b > max_len) begin
                            r.frame_end = 1'b1;
                            r.status = STAT_BADLEN;
                            r.payload_length = b;
                            hunt();
                        end else begin
                            frame_len = b;
                            sum = b;
                            taken = '0;
                            parse_st = ST_BODY;
                        end
                    end
                    default: begin
                        if (taken == frame_len) begin
                            r.frame_end = 1'b1;
                            r.status = (b == 8'(8'd0 - sum)) ? STAT_GOOD : STAT_BADSUM;
                            r.payload_length = frame_len;
                            hunt();
                        end else begin
                            sum = sum + b;
                            taken = taken + 8'd1;
                            r.out_byte = b;
                            r.byte_valid = 1'b1;
                        end
                    end
                endcase
                prev_byte = b;
            end
            result_q.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     checked, what, got, want);
            errors++;
        endtask

        task check_word(t_result got);
            t_result want;
            checked++;
            if (result_q.size() == 0) begin
                report("word with nothing pending, tlast", got.frame_end, 0);
                return;
            end
            want = result_q.pop_front();
            if (got.out_byte != want.out_byte)
                report("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid != want.byte_valid)
                report("byte_valid", got.byte_valid, want.byte_valid);
            if (got.frame_end != want.frame_end)
                report("frame_end", got.frame_end, want.frame_end);
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.payload_length != want.payload_length)
                report("payload_length", got.payload_length, want.payload_length);
        endtask
    endclass

    deframe_board sb = new();

    int burst_left = 0;
    bit gaps_on = 1'b0;
    int rx_mode = 0;
    int stall_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side stalls: always ready, random, or long on/off runs.
    always @(posedge i_clk) begin
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_cnt == 0) begin
                    m_axis_tready <= ~m_axis_tready;
                    stall_cnt <= m_axis_tready ? $urandom_range(1, 8) : $urandom_range(1, 12);
                end else begin
                    stall_cnt <= stall_cnt - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_byte = m_axis_tdata[7:0];
            got.payload_length = m_axis_tdata[15:8];
            got.byte_valid = m_axis_tuser[0];
            got.status = t_status'(m_axis_tuser[3:1]);
            got.frame_end = m_axis_tlast;
            sb.check_word(got);
        end
    end

    task send_word(t_req req, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        sb.note_word(req, b);
    endtask

    function logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? PRE_FIRST : PRE_SECOND;
        return 8'($urandom);
    endfunction

    // Full frame; cut >= 0 sends a timeout in place of the word at that offset and ends the frame there.
    task send_frame(int len, int cut, bit good_sum);
        logic [7:0] fsum;
        logic [7:0] b;
        fsum = 8'(len);
        for (int i = 0; i < len + 4; i++) begin
            if (i == cut) begin
                send_word(REQ_TIMEOUT, 8'($urandom));
                return;
            end
            if (i == 0)
                b = PRE_FIRST;
            else if (i == 1)
                b = PRE_SECOND;
            else if (i == 2)
                b = 8'(len);
            else if (i < len + 3) begin
                b = pick_byte();
                fsum = fsum + b;
            end else begin
                b = 8'(8'd0 - fsum);
                if (!good_sum)
                    b = b ^ 8'($urandom_range(1, 255));
            end
            send_word(REQ_BYTE, b);
            // a rejected length ends the frame right there
            if (i == 2 && (len == 0 || len > sb.max_len))
                return;
        end
    endtask

    task drain();
        int guard;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task random_phase(int n_words);
        int start;
        int pick;
        int len;
        int lim;
        start = sb.accepted;
        while (sb.accepted - start < n_words) begin
            pick = $urandom_range(0, 99);
            lim = (sb.max_len > 8) ? 8 : sb.max_len;
            if (sb.max_len == 0)
                len = $urandom_range(0, 255);
            else if ($urandom_range(0, 99) < 4)
                len = sb.max_len;
            else if ($urandom_range(0, 99) < 10)
                len = (sb.max_len < 255 && $urandom_range(0, 1)) ?
                      $urandom_range(sb.max_len + 1, 255) : 0;
            else if ($urandom_range(0, 99) < 80)
                len = $urandom_range(1, lim);
            else
                len = $urandom_range(1, sb.max_len);
            if (pick < 60) begin
                if ($urandom_range(0, 3) == 0)
                    send_word(REQ_TIMEOUT, 8'($urandom));
                repeat ($urandom_range(0, 2)) send_word(REQ_BYTE, pick_byte());
                send_frame(len, -1, $urandom_range(0, 4) != 0);
            end else if (pick < 75) begin
                send_frame(len, $urandom_range(0, len + 3), 1'b1);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) send_word(REQ_BYTE, pick_byte());
            end else begin
                send_word(REQ_TIMEOUT, 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [7:0] cfg_vals[6];
        cfg_vals[0] = 8'd255;
        cfg_vals[1] = 8'd1;
        cfg_vals[2] = 8'd0;
        cfg_vals[3] = 8'($urandom_range(2, 254));
        cfg_vals[4] = 8'd3;
        cfg_vals[5] = 8'd255;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: timeout while hunting, good frame with extreme payload,
        // zero length, timeouts before and after the length, bad checksum
        gaps_on = 1'b0;
        rx_mode = 0;
        send_word(REQ_TIMEOUT, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_BYTE, 8'h02);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_TIMEOUT, 8'hFF);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_BYTE, 8'h01);
        send_word(REQ_BYTE, 8'hAA);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_BYTE, 8'h03);
        send_word(REQ_BYTE, 8'h12);
        send_word(REQ_TIMEOUT, 8'h5A);
        drain();

        for (int p = 0; p < 6; p++) begin
            i_max_length_we <= 1'b1;
            i_max_length <= cfg_vals[p];
            @(posedge i_clk);
            i_max_length_we <= 1'b0;
            sb.max_len = cfg_vals[p];
            gaps_on = (p % 3 != 0);
            rx_mode = p % 3;
            random_phase(310);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
